// ----- hdl/rhc_pkg.sv -----
package rhc_pkg;

  // Pixel and result field widths
  localparam int CH_W  = 8;
  localparam int OUT_W = 16;

  // Default number of fraction bits of the results
  localparam int FRAC_BITS_DEF = 16;

  // Divider operands: the largest denominator is 6 * 255 = 1530
  localparam int DEN_W = 11;

  // Restoring-division steps done in one divider stage
  localparam int STEPS_PER_STAGE = 4;

  // Lane order inside the divider
  localparam int NUM_LANES = 3;
  localparam int LANE_HUE  = 0;
  localparam int LANE_SAT  = 1;
  localparam int LANE_LIT  = 2;

  // Lightness divisor, and the max+min sum at which lightness reaches one half
  localparam logic [DEN_W-1:0] LIT_DEN  = DEN_W'(510);
  localparam logic [DEN_W-1:0] HALF_SUM = DEN_W'(255);

  // Operands handed from the front end to the divider
  typedef struct packed {
    logic                            grey;
    logic [NUM_LANES-1:0][DEN_W-1:0] num;
    logic [NUM_LANES-1:0][DEN_W-1:0] den;
  } div_req_t;

endpackage

// ----- hdl/rhc_rgb_if.sv -----
interface rhc_rgb_if;
  logic                     valid;
  logic                     ready;
  logic [rhc_pkg::CH_W-1:0] red;
  logic [rhc_pkg::CH_W-1:0] green;
  logic [rhc_pkg::CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ----- hdl/rhc_hsl_if.sv -----
interface rhc_hsl_if;
  logic                      valid;
  logic                      ready;
  logic [rhc_pkg::OUT_W-1:0] hue;
  logic [rhc_pkg::OUT_W-1:0] saturation;
  logic [rhc_pkg::OUT_W-1:0] lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

// ----- hdl/rhc_prep.sv -----
// Front end: max/min search, then numerators and denominators of the three fractions
module rhc_prep (
  input  logic              clk,
  input  logic              rst_n,
  rhc_rgb_if.sink           in_pix,
  output logic              out_valid,
  input  logic              out_ready,
  output rhc_pkg::div_req_t out_req
);

  localparam int CW = rhc_pkg::CH_W;
  localparam int DW = rhc_pkg::DEN_W;

  typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} max_sel_t;

  // stage A registers
  logic          va_r;
  logic [CW-1:0] r_r, g_r, b_r, mx_r, mn_r;
  max_sel_t      sel_r;
  logic [CW-1:0] mx_nxt, mn_nxt;
  max_sel_t      sel_nxt;

  // stage B registers
  logic              vb_r;
  rhc_pkg::div_req_t req_r, req_nxt;

  logic load_a, load_b;

  // each stage takes a request when empty or when it hands its own on
  assign load_b       = !vb_r || out_ready;
  assign load_a       = !va_r || load_b;
  assign in_pix.ready = load_a;

  // largest channel, ties go red, then green
  always_comb begin
    if (in_pix.red >= in_pix.green && in_pix.red >= in_pix.blue) begin
      sel_nxt = MAX_RED;
      mx_nxt  = in_pix.red;
    end else if (in_pix.green >= in_pix.blue) begin
      sel_nxt = MAX_GREEN;
      mx_nxt  = in_pix.green;
    end else begin
      sel_nxt = MAX_BLUE;
      mx_nxt  = in_pix.blue;
    end
    mn_nxt = (in_pix.red <= in_pix.green) ? in_pix.red : in_pix.green;
    if (in_pix.blue < mn_nxt) begin
      mn_nxt = in_pix.blue;
    end
  end

  // delta, sum and the divider operands
  always_comb begin
    logic [DW-1:0] d;
    logic [DW-1:0] sum;
    logic [DW-1:0] rx, gx, bx;
    d   = DW'(mx_r) - DW'(mn_r);
    sum = DW'(mx_r) + DW'(mn_r);
    rx  = DW'(r_r);
    gx  = DW'(g_r);
    bx  = DW'(b_r);

    req_nxt      = '0;
    req_nxt.grey = (d == '0);

    // hue: sector offset plus signed channel difference, wrapped to [0, 6d)
    unique case (sel_r)
      MAX_RED: begin
        if (gx >= bx) begin
          req_nxt.num[rhc_pkg::LANE_HUE] = gx - bx;
        end else begin
          req_nxt.num[rhc_pkg::LANE_HUE] = (d << 2) + (d << 1) - (bx - gx);
        end
      end
      MAX_GREEN: req_nxt.num[rhc_pkg::LANE_HUE] = (d << 1) + bx - rx;
      MAX_BLUE:  req_nxt.num[rhc_pkg::LANE_HUE] = (d << 2) + rx - gx;
      default:   req_nxt.num[rhc_pkg::LANE_HUE] = (d << 2) + rx - gx;
    endcase
    req_nxt.den[rhc_pkg::LANE_HUE] = (d << 2) + (d << 1);

    // saturation: lower or upper half of the lightness range
    req_nxt.num[rhc_pkg::LANE_SAT] = d;
    if (sum < rhc_pkg::HALF_SUM) begin
      req_nxt.den[rhc_pkg::LANE_SAT] = sum;
    end else begin
      req_nxt.den[rhc_pkg::LANE_SAT] = rhc_pkg::LIT_DEN - sum;
    end

    // lightness
    req_nxt.num[rhc_pkg::LANE_LIT] = sum;
    req_nxt.den[rhc_pkg::LANE_LIT] = rhc_pkg::LIT_DEN;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (load_a) begin
        va_r <= in_pix.valid;
      end
      if (load_b) begin
        vb_r <= va_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load_a && in_pix.valid) begin
      r_r   <= in_pix.red;
      g_r   <= in_pix.green;
      b_r   <= in_pix.blue;
      mx_r  <= mx_nxt;
      mn_r  <= mn_nxt;
      sel_r <= sel_nxt;
    end
    if (load_b && va_r) begin
      req_r <= req_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_req   = req_r;

endmodule

// ----- hdl/rhc_divider.sv -----
// Pipelined restoring divider, three lanes side by side.
// Each lane gives floor(num * 2^FRAC_BITS / den) with num <= den, so the
// quotient has one integer bit and FRAC_BITS fraction bits, MSB first.
module rhc_divider #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  rhc_pkg::div_req_t                             in_req,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic                                          out_grey,
  output logic [rhc_pkg::NUM_LANES-1:0][FRAC_BITS:0]    out_quo
);

  localparam int QW     = FRAC_BITS + 1;
  localparam int SPS    = rhc_pkg::STEPS_PER_STAGE;
  localparam int NSTAGE = (QW + SPS - 1) / SPS;
  localparam int DW     = rhc_pkg::DEN_W;
  localparam int RW     = DW + 1;
  localparam int NL     = rhc_pkg::NUM_LANES;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] quo;
  } lane_t;

  logic          vld_r  [NSTAGE];
  logic          grey_r [NSTAGE];
  logic [DW-1:0] den_r  [NSTAGE][NL];
  lane_t         lane_r [NSTAGE][NL];

  logic          src_vld  [NSTAGE];
  logic          src_grey [NSTAGE];
  logic [DW-1:0] src_den  [NSTAGE][NL];
  lane_t         src_lane [NSTAGE][NL];
  lane_t         lane_nxt [NSTAGE][NL];
  logic          load     [NSTAGE];

  // ready chain, back to front
  always_comb begin
    load[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      load[s] = !vld_r[s] || load[s+1];
    end
  end
  assign in_ready = load[0];

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    // stage inputs
    if (s == 0) begin : g_head
      assign src_vld[s]  = in_valid;
      assign src_grey[s] = in_req.grey;
      for (genvar l = 0; l < NL; l++) begin : g_lane
        assign src_den[s][l]       = in_req.den[l];
        assign src_lane[s][l].rem  = RW'(in_req.num[l]);
        assign src_lane[s][l].quo  = '0;
      end
    end else begin : g_body
      assign src_vld[s]  = vld_r[s-1];
      assign src_grey[s] = grey_r[s-1];
      for (genvar l = 0; l < NL; l++) begin : g_lane
        assign src_den[s][l]  = den_r[s-1][l];
        assign src_lane[s][l] = lane_r[s-1][l];
      end
    end

    // this stage's share of the quotient bits
    always_comb begin
      logic [RW-1:0] rem;
      logic [QW-1:0] quo;
      logic          qbit;
      for (int l = 0; l < NL; l++) begin
        rem = src_lane[s][l].rem;
        quo = src_lane[s][l].quo;
        for (int j = 0; j < SPS; j++) begin
          if (s * SPS + j < QW) begin
            // the integer bit compares without a shift
            if (s * SPS + j != 0) begin
              rem = {rem[RW-2:0], 1'b0};
            end
            qbit = (rem >= {1'b0, src_den[s][l]});
            if (qbit) begin
              rem = rem - {1'b0, src_den[s][l]};
            end
            quo = {quo[QW-2:0], qbit};
          end
        end
        lane_nxt[s][l].rem = rem;
        lane_nxt[s][l].quo = quo;
      end
    end

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (load[s]) begin
        vld_r[s] <= src_vld[s];
      end
    end

    // payload
    always_ff @(posedge clk) begin
      if (load[s] && src_vld[s]) begin
        grey_r[s] <= src_grey[s];
        for (int l = 0; l < NL; l++) begin
          den_r[s][l]  <= src_den[s][l];
          lane_r[s][l] <= lane_nxt[s][l];
        end
      end
    end
  end

  assign out_valid = vld_r[NSTAGE-1];
  assign out_grey  = grey_r[NSTAGE-1];
  for (genvar l = 0; l < NL; l++) begin : g_out
    assign out_quo[l] = lane_r[NSTAGE-1][l].quo;
  end

endmodule

// ----- hdl/rgb_to_hsl_convert.sv -----
// RGB to HSL pixel converter.
// in_pix carries one 8-bit red/green/blue pixel per request; out_hsl returns
// hue, saturation and lightness as unsigned fractions times 2^FRAC_BITS
// (low 16 bits), one result per pixel, in order. Both channels use
// valid/ready; a request moves when both are high at a rising clk edge.
// The pipeline has two front-end stages (max/min, then operands), one
// divider stage per four quotient bits of the restoring divider, and the
// output register. Throughput is one pixel per cycle while out_hsl takes
// results; the divider retires four quotient bits of every lane per stage,
// so no stage holds a pixel back to iterate on it.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor takes its request, so a stalled receiver lets the pipeline fill
// its bubbles before in_pix.ready drops; nothing is lost or repeated.
// rst_n (synchronous, active low) empties all stages; no pixel in flight
// survives it and no result is produced from it.
module rgb_to_hsl_convert #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rhc_rgb_if.sink   in_pix,
  rhc_hsl_if.source out_hsl
);

  localparam int QW     = FRAC_BITS + 1;
  localparam int SPS    = rhc_pkg::STEPS_PER_STAGE;
  localparam int NSTAGE = (QW + SPS - 1) / SPS;
  localparam int DEPTH  = NSTAGE + 3;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OW     = rhc_pkg::OUT_W;
  localparam int NL     = rhc_pkg::NUM_LANES;

  logic                      prep_valid, prep_ready;
  rhc_pkg::div_req_t         prep_req;
  logic                      div_valid, div_ready, div_grey;
  logic [NL-1:0][FRAC_BITS:0] div_quo;

  logic          ovld_r;
  logic [OW-1:0] hue_r, sat_r, lit_r;
  logic [OW-1:0] hue_nxt, sat_nxt, lit_nxt;
  logic          load_o;

  // front end
  rhc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_req   (prep_req)
  );

  // divider
  rhc_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_req    (prep_req),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_grey  (div_grey),
    .out_quo   (div_quo)
  );

  assign load_o    = !ovld_r || out_hsl.ready;
  assign div_ready = load_o;

  // clamp a full one to all ones, zero hue and saturation of a grey pixel
  always_comb begin
    logic [FRAC_BITS-1:0] fx [NL];
    for (int l = 0; l < NL; l++) begin
      fx[l] = div_quo[l][FRAC_BITS] ? '1 : div_quo[l][FRAC_BITS-1:0];
      if (div_grey && l != rhc_pkg::LANE_LIT) begin
        fx[l] = '0;
      end
    end
    hue_nxt = OW'(fx[rhc_pkg::LANE_HUE]);
    sat_nxt = OW'(fx[rhc_pkg::LANE_SAT]);
    lit_nxt = OW'(fx[rhc_pkg::LANE_LIT]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (load_o) begin
      ovld_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_o && div_valid) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      lit_r <= lit_nxt;
    end
  end

  assign out_hsl.valid      = ovld_r;
  assign out_hsl.hue        = hue_r;
  assign out_hsl.saturation = sat_r;
  assign out_hsl.lightness  = lit_r;

  // pixels in flight, for the checks below
  logic [CNT_W-1:0] inflight_r, inflight_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_pix.valid && in_pix.ready;
  assign out_acc = out_hsl.valid && out_hsl.ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // never more pixels inside than stages
  a_depth : assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(DEPTH))
    else $error("pipeline holds more pixels than it has stages");

  // input back-pressure only when every stage is full
  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> inflight_r == CNT_W'(DEPTH))
    else $error("input stalled while a stage is empty");

  // a result is only offered for a pixel that was taken in
  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_hsl.valid |-> inflight_r != '0)
    else $error("result offered with no pixel in flight");

endmodule

// ----- test/rhc_hsl_checker.sv -----
module rhc_hsl_checker #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  rhc_rgb_if   pix,
  rhc_hsl_if   hsl,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W  = rhc_pkg::CH_W;
  localparam int OUT_W = rhc_pkg::OUT_W;
  localparam int DEN_W = rhc_pkg::DEN_W;

  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] saturation;
    logic [OUT_W-1:0] lightness;
  } hsl_t;

  hsl_t expected_hsl[$];
  int   mismatches = 0;

  // Truncated fraction num/den times 2^FRAC_BITS, clamped just below one
  function automatic logic [OUT_W-1:0] frac_clamped(input logic [DEN_W-1:0] num,
                                                    input logic [DEN_W-1:0] den);
    logic [63:0] q;
    if (den == '0) return '0;
    q = (64'(num) << FRAC_BITS) / 64'(den);
    if (q > (64'(1) << FRAC_BITS) - 64'(1)) q = (64'(1) << FRAC_BITS) - 64'(1);
    return q[OUT_W-1:0];
  endfunction

  function automatic hsl_t predict_hsl(input logic [CH_W-1:0] r,
                                       input logic [CH_W-1:0] g,
                                       input logic [CH_W-1:0] b);
    logic [DEN_W-1:0] rr, gg, bb, top_ch, low_ch, delta, sum, hue_num;
    hsl_t res;
    rr = DEN_W'(r);
    gg = DEN_W'(g);
    bb = DEN_W'(b);
    top_ch = (rr > gg) ? rr : gg;
    if (bb > top_ch) top_ch = bb;
    low_ch = (rr < gg) ? rr : gg;
    if (bb < low_ch) low_ch = bb;
    delta = top_ch - low_ch;
    sum   = top_ch + low_ch;

    res.lightness  = frac_clamped(sum, rhc_pkg::LIT_DEN);
    res.hue        = '0;
    res.saturation = '0;
    // grey pixels keep hue and saturation at zero
    if (delta != '0) begin
      if (sum < rhc_pkg::HALF_SUM) res.saturation = frac_clamped(delta, sum);
      else res.saturation = frac_clamped(delta, rhc_pkg::LIT_DEN - sum);
      // ties for the largest channel go red, then green, then blue
      if (rr == top_ch) begin
        if (gg >= bb) hue_num = gg - bb;
        else hue_num = DEN_W'(6 * delta - (bb - gg));   // wrap negative hue
      end else if (gg == top_ch) begin
        hue_num = DEN_W'(2 * delta + bb - rr);
      end else begin
        hue_num = DEN_W'(4 * delta + rr - gg);
      end
      res.hue = frac_clamped(hue_num, DEN_W'(6 * delta));
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Predict on every accepted pixel request, compare on every result request
  always @(posedge clk) begin
    hsl_t got;
    hsl_t want;
    if (rst_n) begin
      if (pix.valid && pix.ready)
        expected_hsl.push_back(predict_hsl(pix.red, pix.green, pix.blue));
      if (hsl.valid && hsl.ready) begin
        got = '{hsl.hue, hsl.saturation, hsl.lightness};
        if (expected_hsl.size() == 0) begin
          report_mismatch($sformatf("unexpected result h=%h s=%h l=%h",
                                    got.hue, got.saturation, got.lightness));
        end else begin
          want = expected_hsl.pop_front();
          if (got.hue !== want.hue)
            report_mismatch($sformatf("hue %h, want %h", got.hue, want.hue));
          if (got.saturation !== want.saturation)
            report_mismatch($sformatf("saturation %h, want %h",
                                      got.saturation, want.saturation));
          if (got.lightness !== want.lightness)
            report_mismatch($sformatf("lightness %h, want %h",
                                      got.lightness, want.lightness));
        end
      end
    end
    pending    <= expected_hsl.size();
    fail_count <= mismatches;
  end

endmodule

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W          = rhc_pkg::CH_W;
  localparam int RANDOM_PIXELS = 650;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;

  rhc_rgb_if pix_if ();
  rhc_hsl_if hsl_if ();

  rgb_to_hsl_convert #(.FRAC_BITS(rhc_pkg::FRAC_BITS_DEF)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if),
    .out_hsl (hsl_if)
  );

  rhc_hsl_checker #(.FRAC_BITS(rhc_pkg::FRAC_BITS_DEF)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (pix_if),
    .hsl        (hsl_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Hard stop in case the handshake locks up
  initial begin
    #200_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one pixel request after an idle gap, return once it is taken
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b, input int gap);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  function automatic int corner_level();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 127;
      3: return 128;
      4: return 254;
      default: return 255;
    endcase
  endfunction

  // Random pixel biased toward grey, ties, the lightness midpoint and corners
  function automatic logic [3*CH_W-1:0] shaped_pixel();
    int hi, lo, mid, s;
    hi  = $urandom_range(0, 255);
    lo  = $urandom_range(0, hi);
    mid = $urandom_range(lo, hi);
    case ($urandom_range(0, 9))
      0: begin
        lo  = hi;
        mid = hi;
      end
      1: mid = $urandom_range(0, 1) ? hi : lo;
      2: begin
        s   = $urandom_range(250, 260);
        hi  = $urandom_range((s + 1) / 2, (s > 255) ? 255 : s);
        lo  = s - hi;
        mid = $urandom_range(lo, hi);
      end
      3: return {CH_W'(corner_level()), CH_W'(corner_level()), CH_W'(corner_level())};
      default: return {CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)};
    endcase
    case ($urandom_range(0, 5))
      0: return {CH_W'(hi), CH_W'(mid), CH_W'(lo)};
      1: return {CH_W'(hi), CH_W'(lo), CH_W'(mid)};
      2: return {CH_W'(mid), CH_W'(hi), CH_W'(lo)};
      3: return {CH_W'(lo), CH_W'(hi), CH_W'(mid)};
      4: return {CH_W'(mid), CH_W'(lo), CH_W'(hi)};
      default: return {CH_W'(lo), CH_W'(mid), CH_W'(hi)};
    endcase
  endfunction

  // Sender: reset, directed pixels, random pixels, drain, verdict
  initial begin
    logic [3*CH_W-1:0] px;
    int gap;
    rst_n        <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= '0;
    pix_if.green <= '0;
    pix_if.blue  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // black, white, mid greys
    send_pixel(8'd0,   8'd0,   8'd0,   $urandom_range(0, 4));
    send_pixel(8'd255, 8'd255, 8'd255, $urandom_range(0, 4));
    send_pixel(8'd128, 8'd128, 8'd128, $urandom_range(0, 4));
    send_pixel(8'd127, 8'd127, 8'd127, $urandom_range(0, 4));
    // primaries and secondaries, fully saturated
    send_pixel(8'd255, 8'd0,   8'd0,   $urandom_range(0, 4));
    send_pixel(8'd0,   8'd255, 8'd0,   $urandom_range(0, 4));
    send_pixel(8'd0,   8'd0,   8'd255, $urandom_range(0, 4));
    send_pixel(8'd255, 8'd255, 8'd0,   $urandom_range(0, 4));
    send_pixel(8'd0,   8'd255, 8'd255, $urandom_range(0, 4));
    send_pixel(8'd255, 8'd0,   8'd255, $urandom_range(0, 4));
    // red largest with blue above green: negative hue wraps
    send_pixel(8'd255, 8'd0,   8'd1,   $urandom_range(0, 4));
    send_pixel(8'd200, 8'd10,  8'd150, $urandom_range(0, 4));
    // ties for the largest channel
    send_pixel(8'd90,  8'd200, 8'd200, $urandom_range(0, 4));
    send_pixel(8'd200, 8'd30,  8'd200, $urandom_range(0, 4));
    send_pixel(8'd200, 8'd200, 8'd30,  $urandom_range(0, 4));
    // max+min around the lightness midpoint
    send_pixel(8'd200, 8'd54,  8'd100, $urandom_range(0, 4));
    send_pixel(8'd200, 8'd55,  8'd100, $urandom_range(0, 4));
    send_pixel(8'd200, 8'd56,  8'd100, $urandom_range(0, 4));
    // smallest nonzero deltas at both ends
    send_pixel(8'd1,   8'd0,   8'd0,   $urandom_range(0, 4));
    send_pixel(8'd0,   8'd0,   8'd1,   $urandom_range(0, 4));
    send_pixel(8'd255, 8'd254, 8'd254, $urandom_range(0, 4));
    send_pixel(8'd254, 8'd255, 8'd255, $urandom_range(0, 4));

    // random part, every third block of 50 back to back
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      px  = shaped_pixel();
      gap = ((i / 50) % 3 == 2) ? 0 : $urandom_range(0, 4);
      send_pixel(px[3*CH_W-1:2*CH_W], px[2*CH_W-1:CH_W], px[CH_W-1:0], gap);
    end
    pix_if.valid <= 1'b0;

    // drain, then wait on for stray results
    for (int k = 0; k < 4000 && pending != 0; k++) @(posedge clk);
    repeat (24) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random stalls per result, idle-free stretches, one long hold-off
  initial begin
    int stall;
    int taken;
    taken = 0;
    hsl_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ((taken / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
      // long hold-off so the pipeline fills and in_pix.ready drops
      if (taken == 150) stall = 100;
      if (stall > 0) begin
        hsl_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hsl_if.ready <= 1'b1;
      do @(posedge clk); while (!hsl_if.valid);
      taken++;
    end
  end

endmodule
